// File: src/assert_macros.svh
// Assertion macros shared by the checker of the partition allocator.
// Needs nothing else; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ffpa_pkg.sv
// Shared types and constants of the first-fit partition allocator.
// Has no dependencies; the interfaces, scan controller, top level and checker import it.
package ffpa_pkg;

  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int LIM_W   = IDX_W + 1;
  localparam int COUNT_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Field widths of the channels.
  localparam int MODE_W     = 1;
  localparam int PINDEX_W   = 4;
  localparam int SVALUE_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int GRANT_W    = 4;
  localparam int HOLE_W     = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_PARTITION_COUNT = 3'd0;

  typedef logic [SIZE_BITS-1:0] size_t;

  // Access request from the scan controller to the size memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    size_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: src/ffpa_ifs.sv
// Channel interfaces for the request and response sides of the allocator.
// Depends on ffpa_pkg for field widths.
interface ffpa_req_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PINDEX_W-1:0] partition_index;
  logic [SVALUE_W-1:0] size_value;

  modport source (output valid, mode, partition_index, size_value, input ready);
  modport sink   (input valid, mode, partition_index, size_value, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [GRANT_W-1:0]  granted_partition;
  logic [HOLE_W-1:0]   hole_size;

  modport source (output valid, status, granted_partition, hole_size, input ready);
  modport sink   (input valid, status, granted_partition, hole_size, output ready);
endinterface

// File: src/ffpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffpa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ffpa_scan.sv
// Transaction controller: loads partition sizes, scans the size memory for a
// first fit, keeps the used flags and the response register. Uses ffpa_pkg.
module ffpa_scan import ffpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ffpa_req_if.sink           req,
  ffpa_rsp_if.source         rsp,
  input  logic [COUNT_W-1:0] partition_count,
  output ram_req_t           ram_req,
  input  size_t              ram_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      scan_idx;
  logic [LIM_W-1:0]      limit;
  size_t                 req_size;
  logic [PARTITIONS-1:0] used;
  logic [STATUS_W-1:0]   res_status;
  logic [GRANT_W-1:0]    res_grant;
  logic [HOLE_W-1:0]     res_hole;

  logic             accept;
  logic             load_in_range;
  logic [LIM_W-1:0] limit_next;
  logic             fits;
  logic             last_entry;
  logic             rsp_free;

  assign req.ready     = (state == ST_IDLE);
  assign accept        = req.valid && req.ready;
  assign load_in_range = (int'(req.partition_index) < PARTITIONS);
  assign rsp_free      = !rsp.valid || rsp.ready;

  // A count above the table size searches only the entries that exist.
  always_comb begin
    if (int'(partition_count) > PARTITIONS) begin
      limit_next = LIM_W'(PARTITIONS);
    end else begin
      limit_next = LIM_W'(partition_count);
    end
  end

  assign fits       = !used[scan_idx] && (ram_rdata >= req_size);
  assign last_entry = ((LIM_W'(scan_idx) + LIM_W'(1)) == limit);

  // The memory is read every cycle: entry zero while idle, so that its data is
  // ready in the first scan cycle, and the following entry while scanning.
  always_comb begin
    ram_req.we    = accept && (req.mode == MODE_LOAD) && load_in_range;
    ram_req.waddr = IDX_W'(req.partition_index);
    ram_req.wdata = SIZE_BITS'(req.size_value);
    ram_req.re    = 1'b1;
    ram_req.raddr = (state == ST_SCAN) ? IDX_W'(scan_idx + 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // In the finish state the response register is refilled instead.
      if (rsp.valid && rsp.ready && (state != ST_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_grant <= '0;
            res_hole  <= '0;
            if (req.mode == MODE_LOAD) begin
              if (load_in_range) begin
                used[IDX_W'(req.partition_index)] <= 1'b0;
              end
              res_status <= STATUS_LOADED;
              state      <= ST_FINISH;
            end else begin
              req_size <= SIZE_BITS'(req.size_value);
              limit    <= limit_next;
              scan_idx <= '0;
              if (limit_next == '0) begin
                res_status <= STATUS_NOFIT;
                state      <= ST_FINISH;
              end else begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            used[scan_idx] <= 1'b1;
            res_status     <= STATUS_ALLOC;
            res_grant      <= GRANT_W'(scan_idx);
            res_hole       <= HOLE_W'(ram_rdata - req_size);
            state          <= ST_FINISH;
          end else if (last_entry) begin
            res_status <= STATUS_NOFIT;
            state      <= ST_FINISH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp.valid             <= 1'b1;
            rsp.status            <= res_status;
            rsp.granted_partition <= res_grant;
            rsp.hole_size         <= res_hole;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/first_fit_partition_allocator_unit.sv
// Top level of the first-fit partition allocator: configuration register,
// size memory and scan controller. Uses ffpa_pkg, ffpa_ifs, ffpa_ram, ffpa_scan.
//
//   Channel  Dir  Handshake            Carries
//   req      in   valid/ready          mode, partition_index, size_value
//   rsp      out  valid/ready          status, granted_partition, hole_size
//   apb      in   psel/penable/pready  partition_count at address 0
//
// A load goes from acceptance through the finish state before the next request
// can be taken. A request first scans the entries in order up to the first fit
// (at most the partition count), the size memory is read one entry per cycle.
// Reset clears the used flags, the partition count and the control state.
// A stalled response holds in its register; the controller can still take one
// more transaction, but then waits in its finish state until the register frees.
module first_fit_partition_allocator_unit import ffpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ffpa_req_if.sink           req,
  ffpa_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COUNT_W-1:0] partition_count;
  ram_req_t           ram_req;
  size_t              ram_rdata;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == ADDR_PARTITION_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_count <= '0;
    end else if (cfg_write) begin
      partition_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_PARTITION_COUNT) begin
      prdata = PDATA_W'(partition_count);
    end else begin
      prdata = '0;
    end
  end

  ffpa_ram #(
    .DEPTH (PARTITIONS),
    .WIDTH (SIZE_BITS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  ffpa_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .rsp             (rsp),
    .partition_count (partition_count),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata)
  );

endmodule

// File: src/ffpa_checker.sv
// Port-level checker for the partition allocator, bound to the top level.
// Uses ffpa_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module ffpa_checker import ffpa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [GRANT_W-1:0]  rsp_granted_partition,
  input logic [HOLE_W-1:0]   rsp_hole_size
);

  // A stalled response stays offered and unchanged.
  `FFPA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `FFPA_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable({rsp_status, rsp_granted_partition, rsp_hole_size}))

  // Only a grant carries an index and a hole.
  `FFPA_ASSERT_NOW(a_no_grant_zero, clk, rst, rsp_valid && (rsp_status != STATUS_ALLOC), (rsp_granted_partition == '0) && (rsp_hole_size == '0))

  // One transaction is in work at a time.
  `FFPA_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_partition_allocator_unit ffpa_checker u_ffpa_checker (
  .clk                   (clk),
  .rst                   (rst),
  .req_valid             (req.valid),
  .req_ready             (req.ready),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_status            (rsp.status),
  .rsp_granted_partition (rsp.granted_partition),
  .rsp_hole_size         (rsp.hole_size)
);
